// ===== design/rswc_pkg.sv =====
// shared types, constants and the control store for the rain sensing wiper controller
// no dependencies; every other design file imports this package
package rswc_pkg;

   // averaging, timing and display constants
   localparam int unsigned SAMPLE_COUNT  = 10;
   localparam int unsigned SETTLE_MS     = 10;
   localparam int unsigned PAUSE_UNIT_MS = 1000;
   localparam int unsigned DIGIT_COUNT   = 10;

   // floor(sum / SAMPLE_COUNT) as a multiply by a rounded-up reciprocal
   localparam int unsigned MEAN_SHIFT = 19;
   localparam int unsigned MEAN_MULT  = (2**MEAN_SHIFT + SAMPLE_COUNT - 1) / SAMPLE_COUNT;

   localparam logic [3:0]  SPEED_FULL  = 4'd10;
   localparam logic [3:0]  DIGIT_LAST  = 4'(DIGIT_COUNT - 1);
   localparam logic [9:0]  SENSOR_MAX_RESET = 10'd150;
   localparam logic [15:0] PULSE_MS_RESET   = 16'd1000;
   localparam logic [6:0]  PATTERN_BLANK    = 7'h7f;

   // configuration register indexes
   localparam logic CSR_SENSOR_MAX = 1'b0;
   localparam logic CSR_PULSE_MS   = 1'b1;

   // item kinds on the request side
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // display port images per digit
   localparam logic [7:0] PORT_HI_TAB [DIGIT_COUNT] = '{
      8'hfb, 8'h63, 8'hb7, 8'h77, 8'h6f, 8'h5f, 8'hdf, 8'h73, 8'hff, 8'h7f};
   localparam logic [7:0] PORT_LO_TAB [DIGIT_COUNT] = '{
      8'hff, 8'hfe, 8'hff, 8'hff, 8'hfe, 8'hff, 8'hff, 8'hfe, 8'hff, 8'hff};

   typedef enum logic [1:0] {
      PH_SAMPLE = 2'd0,
      PH_DRIVE  = 2'd1,
      PH_PAUSE  = 2'd2,
      PH_SETTLE = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      OP_FETCH,
      OP_CHK_TICK,
      OP_CHK_SAMP,
      OP_ADD,
      OP_MEAN,
      OP_CLAMP,
      OP_DIV,
      OP_SPEED,
      OP_TICK,
      OP_ENTER,
      OP_EMIT
   } op_type;

   typedef logic [3:0] step_type;

   typedef struct packed {
      op_type     op;
      step_type   target;
      logic [1:0] shamt;
   } ctl_word_type;

   typedef struct packed {
      logic jump;
      logic hold;
   } seq_status_type;

   // microprogram addresses
   localparam step_type STEP_FETCH    = 4'd0;
   localparam step_type STEP_CHK_TICK = 4'd1;
   localparam step_type STEP_CHK_SAMP = 4'd2;
   localparam step_type STEP_ADD      = 4'd3;
   localparam step_type STEP_MEAN     = 4'd4;
   localparam step_type STEP_CLAMP    = 4'd5;
   localparam step_type STEP_DIV3     = 4'd6;
   localparam step_type STEP_DIV2     = 4'd7;
   localparam step_type STEP_DIV1     = 4'd8;
   localparam step_type STEP_DIV0     = 4'd9;
   localparam step_type STEP_SPEED    = 4'd10;
   localparam step_type STEP_TICK     = 4'd11;
   localparam step_type STEP_ENTER    = 4'd12;
   localparam step_type STEP_EMIT     = 4'd13;

   // control store
   function automatic ctl_word_type micro_rom(input step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_FETCH:    w = '{op: OP_FETCH,    target: STEP_FETCH, shamt: 2'd0};
         STEP_CHK_TICK: w = '{op: OP_CHK_TICK, target: STEP_TICK,  shamt: 2'd0};
         STEP_CHK_SAMP: w = '{op: OP_CHK_SAMP, target: STEP_EMIT,  shamt: 2'd0};
         STEP_ADD:      w = '{op: OP_ADD,      target: STEP_EMIT,  shamt: 2'd0};
         STEP_MEAN:     w = '{op: OP_MEAN,     target: STEP_FETCH, shamt: 2'd0};
         STEP_CLAMP:    w = '{op: OP_CLAMP,    target: STEP_FETCH, shamt: 2'd0};
         STEP_DIV3:     w = '{op: OP_DIV,      target: STEP_FETCH, shamt: 2'd3};
         STEP_DIV2:     w = '{op: OP_DIV,      target: STEP_FETCH, shamt: 2'd2};
         STEP_DIV1:     w = '{op: OP_DIV,      target: STEP_FETCH, shamt: 2'd1};
         STEP_DIV0:     w = '{op: OP_DIV,      target: STEP_FETCH, shamt: 2'd0};
         STEP_SPEED:    w = '{op: OP_SPEED,    target: STEP_ENTER, shamt: 2'd0};
         STEP_TICK:     w = '{op: OP_TICK,     target: STEP_EMIT,  shamt: 2'd0};
         STEP_ENTER:    w = '{op: OP_ENTER,    target: STEP_EMIT,  shamt: 2'd0};
         STEP_EMIT:     w = '{op: OP_EMIT,     target: STEP_FETCH, shamt: 2'd0};
         default:       w = '{op: OP_FETCH,    target: STEP_FETCH, shamt: 2'd0};
      endcase
      return w;
   endfunction

   // seven-segment image: upper six port bits above the low segment bit
   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      return {PORT_HI_TAB[digit][7:2], PORT_LO_TAB[digit][0]};
   endfunction

endpackage

// ===== design/rswc_sequencer.sv =====
// step counter and control store lookup for the wiper controller
// depends on rswc_pkg
module rswc_sequencer
   import rswc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctl_word_type   ctl
);

   step_type pc_ff;
   step_type pc_in;

   // current control word
   assign ctl = micro_rom(pc_ff);

   // hold, branch or fall through
   always_comb begin
      priority if (status.hold) begin
         pc_in = pc_ff;
      end else if (status.jump) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== design/rswc_datapath.sv =====
// datapath of the wiper controller: averaging, speed divide, phase timer, result register
// depends on rswc_pkg; driven one control word per cycle by rswc_sequencer
module rswc_datapath
   import rswc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ctl_word_type   ctl,
   output seq_status_type status,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           req_type,
   input  logic [9:0]     sample_value,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [15:0]    csr_wdata
);

   logic        type_ff, type_in;
   logic [9:0]  sample_ff, sample_in;
   logic [13:0] sum_ff, sum_in;
   logic [3:0]  idx_ff, idx_in;
   phase_type   phase_ff, phase_in;
   phase_type   tgt_ff, tgt_in;
   logic [15:0] ms_ff, ms_in;
   logic        dir_ff, dir_in;
   logic [3:0]  speed_ff, speed_in;
   logic [6:0]  pattern_ff, pattern_in;
   logic [13:0] mean_ff, mean_in;
   logic [13:0] rem_ff, rem_in;
   logic [3:0]  quo_ff, quo_in;
   logic [9:0]  max_ff, max_in;
   logic [15:0] pulse_ff, pulse_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [3:0]  idx_next;
   logic [33:0] mean_prod;
   logic [9:0]  clamped;
   logic [13:0] divisor;
   logic [15:0] ms_dec;
   logic [15:0] pause_len;
   logic [15:0] phase_len;
   logic        driving;
   logic        out_free;

   assign req_tready = (ctl.op == OP_FETCH);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared arithmetic
   assign idx_next  = idx_ff + 4'd1;
   assign mean_prod = 34'(sum_ff) * 34'(MEAN_MULT);
   assign clamped   = (mean_ff > 14'(max_ff)) ? max_ff : mean_ff[9:0];
   assign divisor   = 14'(max_ff) << ctl.shamt;
   assign ms_dec    = (ms_ff != 16'd0) ? ms_ff - 16'd1 : ms_ff;
   assign pause_len = 16'(32'(SPEED_FULL - speed_ff) * PAUSE_UNIT_MS);
   assign driving   = (phase_ff == PH_DRIVE);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // length of the phase about to be entered
   always_comb begin
      unique case (tgt_ff)
         PH_DRIVE:  phase_len = pulse_ff;
         PH_PAUSE:  phase_len = pause_len;
         PH_SETTLE: phase_len = 16'(SETTLE_MS);
         default:   phase_len = 16'd0;
      endcase
   end

   // configuration writes
   always_comb begin
      max_in   = max_ff;
      pulse_in = pulse_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_MAX: max_in   = csr_wdata[9:0];
            CSR_PULSE_MS:   pulse_in = csr_wdata;
            default:        max_in   = max_ff;
         endcase
      end
   end

   // micro-operation decode
   always_comb begin
      type_in      = type_ff;
      sample_in    = sample_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      tgt_in       = tgt_ff;
      ms_in        = ms_ff;
      dir_in       = dir_ff;
      speed_in     = speed_ff;
      pattern_in   = pattern_ff;
      mean_in      = mean_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      status       = '0;

      unique case (ctl.op)
         OP_FETCH: begin
            status.hold = !accept;
            type_in     = req_type;
            sample_in   = sample_value;
         end
         OP_CHK_TICK: begin
            status.jump = (type_ff == REQ_TICK);
         end
         OP_CHK_SAMP: begin
            // samples are dropped outside the sampling phase
            status.jump = (phase_ff != PH_SAMPLE);
         end
         OP_ADD: begin
            sum_in      = sum_ff + 14'(sample_ff);
            idx_in      = idx_next;
            status.jump = ({1'b0, idx_next} < 5'(SAMPLE_COUNT));
         end
         OP_MEAN: begin
            mean_in = mean_prod[MEAN_SHIFT +: 14];
         end
         OP_CLAMP: begin
            rem_in = 14'({clamped, 3'b000}) + 14'({clamped, 1'b0});
            quo_in = 4'd0;
         end
         OP_DIV: begin
            // one restoring step; a zero divisor leaves the quotient at zero
            if (max_ff != 10'd0 && rem_ff >= divisor) begin
               rem_in = rem_ff - divisor;
               quo_in = quo_ff | (4'b0001 << ctl.shamt);
            end
         end
         OP_SPEED: begin
            speed_in    = quo_ff;
            pattern_in  = seg_pattern((quo_ff > DIGIT_LAST) ? DIGIT_LAST : quo_ff);
            status.jump = 1'b1;
            if (quo_ff != 4'd0) begin
               dir_in = ~dir_ff;
               tgt_in = PH_DRIVE;
            end else begin
               tgt_in = PH_SETTLE;
            end
         end
         OP_TICK: begin
            // ticks while sampling are ignored
            if (phase_ff == PH_SAMPLE) begin
               status.jump = 1'b1;
            end else begin
               ms_in = ms_dec;
               if (ms_dec == 16'd0) begin
                  tgt_in = phase_type'(phase_ff + 2'd1);
               end else begin
                  status.jump = 1'b1;
               end
            end
         end
         OP_ENTER: begin
            // zero-length phases are stepped over, one per cycle
            phase_in = tgt_ff;
            if (tgt_ff == PH_SAMPLE) begin
               sum_in = 14'd0;
               idx_in = 4'd0;
               ms_in  = 16'd0;
            end else if (phase_len != 16'd0) begin
               ms_in = phase_len;
            end else begin
               tgt_in      = phase_type'(tgt_ff + 2'd1);
               status.hold = 1'b1;
            end
         end
         OP_EMIT: begin
            status.hold = !out_free;
            status.jump = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, (phase_ff == PH_SAMPLE), speed_ff, pattern_ff[0],
                               pattern_ff[6:1], driving & ~dir_ff, driving & dir_ff};
            end
         end
         default: begin
            status = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         idx_ff       <= '0;
         phase_ff     <= PH_SAMPLE;
         ms_ff        <= '0;
         dir_ff       <= 1'b0;
         speed_ff     <= '0;
         pattern_ff   <= PATTERN_BLANK;
         max_ff       <= SENSOR_MAX_RESET;
         pulse_ff     <= PULSE_MS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         ms_ff        <= ms_in;
         dir_ff       <= dir_in;
         speed_ff     <= speed_in;
         pattern_ff   <= pattern_in;
         max_ff       <= max_in;
         pulse_ff     <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      sample_ff   <= sample_in;
      tgt_ff      <= tgt_in;
      mean_ff     <= mean_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_sample_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SAMPLE) |-> (ms_ff == 16'd0))
      else $error("timer not clear while sampling");

   a_timed_phase_armed: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_FETCH && phase_ff != PH_SAMPLE) |-> (ms_ff != 16'd0))
      else $error("timed phase idle with expired timer");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_SPEED) |-> (quo_ff <= SPEED_FULL))
      else $error("speed divide out of range");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == OP_EMIT))
      else $error("result raised outside emit step");
`endif

endmodule

// ===== design/rain_sensing_wiper_controller.sv =====
// top level of the rain sensing wiper controller
// depends on rswc_pkg, rswc_sequencer and rswc_datapath
//
// Each request item is a rain sensor sample (tuser 0) or a 1 ms tick (tuser 1), and each one
// produces exactly one response item holding the drive lines, the latched seven-segment
// image, the last speed (0 to 10) and whether samples are being taken. Every tenth sample
// taken while sampling closes an average: the mean is clamped to sensor_max, the speed is
// mean*10/sensor_max, and a nonzero speed flips direction and starts drive, pause and
// settle phases timed in ticks; samples outside sampling and ticks during sampling change
// nothing. Work is run by a microcoded step sequencer, one item at a time. A sample that
// closes an average also passes through the mean multiply, the clamp and the four-step
// restoring divide, and zero-length phases are stepped over one at a time. The response
// register lets the next item be taken while a result still waits; the emit step of that
// next item stalls until the waiting result is taken. csr_index 0 writes sensor_max (reset
// 150), index 1 writes pulse_ms (reset 1000); write them only while the block is idle.
module rain_sensing_wiper_controller
   import rswc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample_value, [15:10] zero
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] drive_forward, [1] drive_reverse,
                                    // [7:2] segment_upper, [8] segment_lowbit,
                                    // [12:9] speed_level, [13] sampling, [15:14] zero
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ctl_word_type   ctl;
   seq_status_type status;

   // step counter and control store
   rswc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // datapath and response register
   rswc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .status       (status),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_type     (req_tuser[0]),
      .sample_value (req_tdata[9:0]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index[0]),
      .csr_wdata    (csr_wdata)
   );

endmodule

// ===== test/wiper_checker.sv =====
// result checker for the rain sensing wiper controller: predicts and compares every item
// depends on rswc_pkg for the phase enum, item kinds, register indexes and timing constants
module wiper_checker
   import rswc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample_value, [15:10] zero
   input  logic [0:0]  req_tuser,   // [0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [0] drive_forward, [1] drive_reverse,
                                    // [7:2] segment_upper, [8] segment_lowbit,
                                    // [12:9] speed_level, [13] sampling, [15:14] zero
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          pending_results,
   output int          failure_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // one result item, laid out as rsp_tdata[13:0]
   typedef struct packed {
      logic       sampling;
      logic [3:0] speed;
      logic       seg_low;
      logic [5:0] seg_upper;
      logic       rev;
      logic       fwd;
   } wiper_view_type;

   // digit images as {upper six port bits, low segment bit}
   localparam logic [6:0] DIGIT_IMAGE [10] = '{
      7'h7d, 7'h30, 7'h5b, 7'h3b, 7'h36, 7'h2f, 7'h6f, 7'h38, 7'h7f, 7'h3f};

   // predicted controller state and register copies
   logic [13:0]    acc_sum;
   logic [3:0]     acc_count;
   phase_type      ph;
   logic [15:0]    ticks_left;
   logic           dir;
   logic [3:0]     speed;
   logic [6:0]     image;
   logic [9:0]     max_lvl;
   logic [15:0]    wipe_ms;

   wiper_view_type expected_views[$];
   int             fails;

   function automatic void clear_wiper();
      acc_sum    = '0;
      acc_count  = '0;
      ph         = PH_SAMPLE;
      ticks_left = '0;
      dir        = 1'b0;
      speed      = '0;
      image      = 7'h7f;
      max_lvl    = SENSOR_MAX_RESET;
      wipe_ms    = PULSE_MS_RESET;
   endfunction

   // step into a phase, passing over timed phases of zero length
   function automatic void enter_phase(input phase_type start_ph);
      int unsigned span;
      phase_type   target_ph;
      target_ph = start_ph;
      for (int hop = 0; hop < 4; hop++) begin
         case (target_ph)
            PH_SAMPLE: begin
               ph         = PH_SAMPLE;
               acc_sum    = '0;
               acc_count  = '0;
               ticks_left = '0;
               return;
            end
            PH_DRIVE:  span = wipe_ms;
            PH_PAUSE:  span = (10 - speed) * PAUSE_UNIT_MS;
            default:   span = SETTLE_MS;
         endcase
         span &= 32'hffff;
         if (span != 0) begin
            ph         = target_ph;
            ticks_left = 16'(span);
            return;
         end
         target_ph = phase_type'(2'(target_ph + 2'd1));
      end
   endfunction

   // mean of the sample set, clamp, speed and display latch
   function automatic void close_average();
      int unsigned mean;
      int unsigned spd;
      mean = acc_sum / SAMPLE_COUNT;
      spd  = 0;
      if (max_lvl == 0) begin
         mean = 0;
      end else begin
         if (mean > max_lvl) mean = max_lvl;
         spd = (mean * 10) / max_lvl;
      end
      speed = 4'(spd);
      image = DIGIT_IMAGE[(speed > 9) ? 9 : speed];
      if (speed != 0) begin
         dir = ~dir;
         enter_phase(PH_DRIVE);
      end else begin
         enter_phase(PH_SETTLE);
      end
   endfunction

   // controller outputs after one item
   function automatic wiper_view_type wiper_after_item(input logic kind, input logic [9:0] level);
      wiper_view_type view;
      if (kind == REQ_SAMPLE) begin
         if (ph == PH_SAMPLE) begin
            acc_sum   = acc_sum + level;
            acc_count = acc_count + 4'd1;
            if (acc_count >= SAMPLE_COUNT) close_average();
         end
      end else if (ph != PH_SAMPLE) begin
         if (ticks_left > 0) ticks_left = ticks_left - 16'd1;
         if (ticks_left == 0) enter_phase(phase_type'(2'(ph + 2'd1)));
      end
      view.fwd       = (ph == PH_DRIVE) && dir;
      view.rev       = (ph == PH_DRIVE) && !dir;
      view.seg_upper = image[6:1];
      view.seg_low   = image[0];
      view.speed     = speed;
      view.sampling  = (ph == PH_SAMPLE);
      return view;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fails++;
      end
   endfunction

   function automatic void check_result(input logic [15:0] word);
      wiper_view_type want;
      wiper_view_type got;
      got = wiper_view_type'(word[13:0]);
      if (expected_views.size() == 0) begin
         $display("%0t ns: result item %h with nothing expected", $time, word);
         fails++;
      end else begin
         want = expected_views.pop_front();
         check_field("drive_forward", want.fwd, got.fwd);
         check_field("drive_reverse", want.rev, got.rev);
         check_field("segment_upper", want.seg_upper, got.seg_upper);
         check_field("segment_lowbit", want.seg_low, got.seg_low);
         check_field("speed_level", want.speed, got.speed);
         check_field("sampling", want.sampling, got.sampling);
      end
   endfunction

   initial begin
      fails = 0;
      clear_wiper();
   end

   // watch both channels and the register port at each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_wiper();
         expected_views.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            expected_views.push_back(wiper_after_item(req_tuser[0], req_tdata[9:0]));
         if (csr_we) begin
            if (csr_index == CSR_SENSOR_MAX) max_lvl = csr_wdata[9:0];
            else if (csr_index == CSR_PULSE_MS) wipe_ms = csr_wdata;
         end
      end
      pending_results <= expected_views.size();
      failure_count   <= fails;
   end

endmodule

// ===== test/tb.sv =====
// top of the rain sensing wiper controller testbench: clock, reset, stimulus and verdict
// depends on rswc_pkg, the controller RTL and wiper_checker
module tb;
   import rswc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEM_GOAL = 1050;
   localparam int unsigned HOLD_CYCLES = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [9:0] sample_value, [15:10] zero
   logic [0:0]  req_tuser;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [0] drive_forward, [1] drive_reverse,
                             // [7:2] segment_upper, [8] segment_lowbit,
                             // [12:9] speed_level, [13] sampling, [15:14] zero
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   int          pending_results;
   int          failure_count;

   // stimulus shaping state
   bit          jitter_on;
   bit          hold_off_request;
   logic [9:0]  cur_max;
   logic [15:0] cur_pulse;
   int unsigned items_done;

   rain_sensing_wiper_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wiper_checker watch (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .failure_count   (failure_count)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("rain_sensing_wiper_controller test failed");
      $finish;
   end

   // result side: short random stalls, plus one long hold-off on request
   initial begin
      int ready_gap;
      ready_gap = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (ready_gap > 0) begin
            rsp_tready <= 1'b0;
            ready_gap--;
         end else if (hold_off_request) begin
            hold_off_request <= 1'b0;
            rsp_tready <= 1'b0;
            ready_gap = HOLD_CYCLES - 1;
         end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            ready_gap = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one item and hold it until taken
   task automatic push_item(input logic kind, input logic [9:0] level);
      if (jitter_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_done++;
   endtask

   // stop offering and let every outstanding result drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(input logic [9:0] max_lvl, input logic [15:0] wipe_ms);
      csr_we    <= 1'b1;
      csr_index <= CSR_SENSOR_MAX;
      csr_wdata <= {6'($urandom), max_lvl};
      @(posedge clock);
      csr_index <= CSR_PULSE_MS;
      csr_wdata <= wipe_ms;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_max   = max_lvl;
      cur_pulse = wipe_ms;
   endtask

   // one sample set and the ticks that carry the wipe cycle back to sampling;
   // speed is steered to 0 or 10, or to 9 for the one long pause
   task automatic run_round(input bit speed_nine);
      int unsigned spd;
      int unsigned busy;
      logic [9:0]  level;
      if (items_done + 150 >= ITEM_GOAL) jitter_on = 1'b0;
      if (speed_nine) spd = 9;
      else if (cur_max == 0 || $urandom_range(0, 2) == 0) spd = 0;
      else spd = 10;
      for (int k = 0; k < SAMPLE_COUNT; k++) begin
         if (cur_max == 0) level = 10'($urandom);
         else if (spd == 0) level = 10'($urandom_range(0, (cur_max - 1) / 10));
         else if (spd == 9) level = 10'($urandom_range(930, 1010));
         else level = 10'($urandom_range(cur_max, 1023));
         // stray tick while sampling
         if ($urandom_range(0, 9) == 0) push_item(REQ_TICK, 10'($urandom));
         push_item(REQ_SAMPLE, level);
      end
      busy = SETTLE_MS;
      if (spd != 0) busy += cur_pulse + (10 - spd) * PAUSE_UNIT_MS;
      for (int k = 0; k < busy; k++) begin
         // stray sample while busy
         if ($urandom_range(0, 7) == 0) push_item(REQ_SAMPLE, 10'($urandom));
         push_item(REQ_TICK, 10'($urandom));
      end
   endtask

   // stimulus
   initial begin
      int rounds;
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      req_tuser        <= REQ_SAMPLE;
      csr_we           <= 1'b0;
      csr_index        <= CSR_SENSOR_MAX;
      csr_wdata        <= '0;
      hold_off_request <= 1'b0;
      jitter_on  = 1'b0;
      cur_max    = SENSOR_MAX_RESET;
      cur_pulse  = PULSE_MS_RESET;
      items_done = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, a low set giving speed zero, busy sample, settle
      push_item(REQ_TICK, 10'h3ff);
      for (int k = 0; k < SAMPLE_COUNT; k++) push_item(REQ_SAMPLE, (k == 4) ? 10'd140 : 10'd0);
      push_item(REQ_SAMPLE, 10'h3ff);
      for (int k = 0; k < SETTLE_MS; k++) push_item(REQ_TICK, 10'($urandom));

      // random phases, each under its own register settings
      for (int setting = 0; setting < 4 || items_done < ITEM_GOAL; setting++) begin
         wait_idle();
         case (setting)
            0:       set_config(10'd1, 16'd0);
            1:       set_config(10'd1023, 16'd1);
            2:       set_config(10'd0, 16'hffff);
            default: set_config(10'($urandom_range(1, 1023)), 16'($urandom_range(1, 6)));
         endcase
         jitter_on = ($urandom_range(0, 3) != 0);
         if (setting == 0) hold_off_request <= 1'b1;
         rounds = $urandom_range(2, 4);
         for (int r = 0; r < rounds; r++) run_round(setting == 1 && r == 0);
      end

      // drain and verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 2000 && pending_results != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failure_count == 0 && pending_results == 0) begin
         $display("rain_sensing_wiper_controller test passed");
      end else begin
         $display("rain_sensing_wiper_controller test failed");
      end
      $finish;
   end

endmodule
